/* rtl/hscm_pkg.sv */
// Package for the Helix stream cipher with MAC: types, constants and
// helper functions shared by the round unit, the sequencer and the top level.
package hscm_pkg;

    localparam int TagBytes = 16;
    localparam logic [31:0] FinishConst = 32'h912d94f1;
    localparam logic [31:0] KeyLenBias = 32'd64;

    localparam logic [2:0] RegKey0  = 3'd0;
    localparam logic [2:0] RegKey1  = 3'd1;
    localparam logic [2:0] RegKey2  = 3'd2;
    localparam logic [2:0] RegKey3  = 3'd3;
    localparam logic [2:0] RegKlen  = 3'd4;
    localparam logic [2:0] RegNlow  = 3'd5;
    localparam logic [2:0] RegNhigh = 3'd6;
    localparam logic [2:0] RegDir   = 3'd7;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] mix_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KLOAD,
        ST_KMIX,
        ST_NLOAD,
        ST_NMIX,
        ST_DATA,
        ST_EMIT,
        ST_FIN,
        ST_TAG,
        ST_OUT
    } state_t;

    // control bundle from sequencer to round unit
    typedef struct packed {
        logic  start;
        word_t x0;
        word_t p;
        word_t x1;
    } round_ctl_t;

    function automatic word_t rol(input word_t x, input int n);
        rol = (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t byte_mask(input logic [2:0] n);
        word_t m;
        m = '0;
        unique case (n)
            3'd0: m = 32'h0;
            3'd1: m = 32'h000000FF;
            3'd2: m = 32'h0000FFFF;
            3'd3: m = 32'h00FFFFFF;
            default: m = 32'hFFFFFFFF;
        endcase
        byte_mask = m;
    endfunction

endpackage

/* rtl/helix_stream_cipher_with_mac.sv */
// Top level: APB registers, stream handshake, message sequencer and key state.
// Depends on hscm_pkg and hscm_round.
//
// channel | dir | tdata fields (low first)        | tuser
// s_      | in  | word_in[31:0], valid_bytes[34:32], last on tlast | req_type
// m_      | out | word_out[31:0], tag_ok[32], last on tlast         | kind
//
// One Helix block holds the shared round unit: a start loads it, then its round
// phases run. A data word is one block; the first word of a message adds 8 key
// and 8 nonce blocks plus the key and nonce load states. The last word adds 11
// finish blocks (started once its data item is taken) and 4 tag items. Reset is
// synchronous, active low; s_tready is low while an item is in work or its
// results wait on m_tready.
module helix_stream_cipher_with_mac (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // word_in[31:0], valid_bytes[34:32]
    input  logic        s_tuser,  // req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // word_out[31:0], tag_ok[32]
    output logic        m_tuser,  // kind
    output logic        m_tlast
);
    import hscm_pkg::*;

    logic [63:0] key_reg [4];
    logic [5:0]  klen_reg;
    logic [63:0] nlow_reg, nhigh_reg;
    logic        dir_reg;

    state_t      state_reg, state_next;
    mix_t        mix_reg;
    word_t       wk_reg [8];
    word_t       rk_reg [8];
    word_t       cnt_reg;
    logic        inmsg_reg;
    word_t       tag_reg [4];
    logic [1:0]  tidx_reg;
    logic        mism_reg;
    logic [3:0]  iter_reg;     // block count within a phase
    word_t       word_reg;
    logic        last_reg;
    logic [2:0]  vb_reg;
    logic [1:0]  lm4_reg;
    // output register
    logic        ov_reg, okind_reg, olast_reg, ook_reg;
    word_t       oword_reg;
    // round unit busy tracker
    logic        u_busy;

    round_ctl_t  ctl;
    mix_t        rstate_in, rstate_out;
    logic        rdone;

    hscm_round u_round (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .state_in(rstate_in), .state_out(rstate_out), .done(rdone)
    );

    wire   wr = psel && penable && pwrite && pready;
    wire [2:0] widx = paddr[5:3];
    assign pready = 1'b1;

    always_comb begin
        unique case (widx)
            RegKey0:  prdata = key_reg[0];
            RegKey1:  prdata = key_reg[1];
            RegKey2:  prdata = key_reg[2];
            RegKey3:  prdata = key_reg[3];
            RegKlen:  prdata = {58'd0, klen_reg};
            RegNlow:  prdata = nlow_reg;
            RegNhigh: prdata = nhigh_reg;
            default:  prdata = {63'd0, dir_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            klen_reg <= '0; nlow_reg <= '0; nhigh_reg <= '0; dir_reg <= 1'b0;
        end else if (wr) begin
            unique case (widx)
                RegKey0:  key_reg[0] <= pwdata;
                RegKey1:  key_reg[1] <= pwdata;
                RegKey2:  key_reg[2] <= pwdata;
                RegKey3:  key_reg[3] <= pwdata;
                RegKlen:  klen_reg <= pwdata[5:0];
                RegNlow:  nlow_reg <= pwdata;
                RegNhigh: nhigh_reg <= pwdata;
                default:  dir_reg <= pwdata[0];
            endcase
        end
    end

    wire [5:0]  klen = (klen_reg > 6'd32) ? 6'd32 : klen_reg;
    wire [255:0] key_flat = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    wire [2:0]  cidx = cnt_reg[2:0];
    wire word_t n0 = nlow_reg[31:0],  n1 = nlow_reg[63:32];
    wire word_t n2 = nhigh_reg[31:0], n3 = nhigh_reg[63:32];
    word_t nn [8];
    always_comb begin
        nn[0] = n0; nn[1] = n1; nn[2] = n2; nn[3] = n3;
        nn[4] = 32'd0 - n0; nn[5] = 32'd1 - n1;
        nn[6] = 32'd2 - n2; nn[7] = 32'd3 - n3;
    end

    wire   accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    wire   take_out = ov_reg && m_tready;
    wire [2:0] vb_in = s_tdata[34:32];
    wire [2:0] vb_eff = (!s_tlast || vb_in == 3'd0 || vb_in > 3'd4) ? 3'd4 : vb_in;
    wire word_t dmask = byte_mask(vb_reg);
    wire word_t plain = dir_reg ? ((word_reg ^ mix_reg[0]) & dmask) : (word_reg & dmask);
    wire [3:0]  tbase = {tidx_reg, 2'b00};
    wire word_t tmask = byte_mask((5'(TagBytes) > {1'b0, tbase}) ?
        3'((5'(TagBytes) - {1'b0, tbase}) > 5'd4 ? 5'd4 : (5'(TagBytes) - {1'b0, tbase}))
        : 3'd0);

    // launch a block whenever the state asks and the unit is idle
    logic launch_reg;
    always_comb begin
        ctl.start = launch_reg;
        ctl.x0 = 32'd0; ctl.p = 32'd0; ctl.x1 = 32'd0;
        rstate_in = mix_reg;
        unique case (state_reg)
            ST_KMIX: begin
                rstate_in = {{26'd0, klen} + KeyLenBias, wk_reg[3], wk_reg[2],
                             wk_reg[1], wk_reg[0]};
            end
            ST_NMIX, ST_DATA, ST_FIN, ST_TAG: begin
                ctl.x0 = wk_reg[cidx];
                ctl.x1 = rk_reg[cidx] + cnt_reg;
                ctl.p  = (state_reg == ST_DATA) ? plain
                       : (state_reg == ST_NMIX) ? 32'd0 : {30'd0, lm4_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && !s_tuser) state_next = inmsg_reg ? ST_DATA : ST_KLOAD;
            ST_KLOAD: state_next = ST_KMIX;
            ST_KMIX:  if (rdone && iter_reg == 4'd7) state_next = ST_NLOAD;
            ST_NLOAD: state_next = ST_NMIX;
            ST_NMIX:  if (rdone && iter_reg == 4'd7) state_next = ST_DATA;
            ST_DATA:  if (rdone) state_next = last_reg ? ST_FIN : ST_IDLE;
            ST_FIN:   if (rdone && iter_reg == 4'd7) state_next = ST_TAG;
            ST_TAG:   if (rdone && iter_reg == 4'd2) state_next = ST_OUT;
            ST_OUT:   if (take_out && iter_reg == 4'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mix_reg <= '0; cnt_reg <= '0; inmsg_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin wk_reg[i] <= '0; rk_reg[i] <= '0; end
            tidx_reg <= '0; mism_reg <= 1'b0; iter_reg <= '0;
            ov_reg <= 1'b0; launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= 1'b0;
            if (take_out) ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (accept) begin
                    word_reg <= s_tdata[31:0];
                    last_reg <= s_tlast;
                    vb_reg   <= vb_eff;
                    lm4_reg  <= vb_eff[1:0];
                    iter_reg <= '0;
                    if (!s_tuser) begin
                        if (inmsg_reg) launch_reg <= 1'b1;
                    end else if (dir_reg && !inmsg_reg) begin
                        if (((s_tdata[31:0] ^ tag_reg[tidx_reg]) & tmask) != 32'd0)
                            mism_reg <= 1'b1;
                        tidx_reg <= tidx_reg + 2'd1;
                        if (s_tlast) begin
                            ov_reg <= 1'b1; okind_reg <= 1'b1; oword_reg <= '0;
                            ook_reg <= !(mism_reg ||
                                (((s_tdata[31:0] ^ tag_reg[tidx_reg]) & tmask) != 32'd0));
                            olast_reg <= 1'b1;
                            tidx_reg <= '0; mism_reg <= 1'b0;
                        end
                    end
                end
                ST_KLOAD: begin
                    for (int i = 0; i < 8; i++)
                        for (int j = 0; j < 4; j++)
                            wk_reg[i][8*j +: 8] <= (6'(4*i+j) < klen) ?
                                key_flat[8*(4*i+j) +: 8] : 8'd0;
                    launch_reg <= 1'b1;
                    inmsg_reg <= 1'b1;
                end
                ST_KMIX: if (rdone) begin
                    for (int i = 0; i < 4; i++) begin
                        wk_reg[i]   <= wk_reg[i+4] ^ rstate_out[i];
                        wk_reg[i+4] <= wk_reg[i];
                    end
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg != 4'd7) launch_reg <= 1'b1;
                end
                ST_NLOAD: begin
                    for (int i = 0; i < 8; i++)
                        rk_reg[i] <= wk_reg[(i+4)%8] + nn[i] +
                            ((i%4) == 1 ? {24'd0, klen, 2'b00} : 32'd0);
                    mix_reg <= {wk_reg[7], wk_reg[6] ^ n3, wk_reg[5] ^ n2,
                                wk_reg[4] ^ n1, wk_reg[3] ^ n0};
                    cnt_reg <= '0; iter_reg <= '0;
                    launch_reg <= 1'b1;
                end
                ST_NMIX: if (rdone) begin
                    mix_reg <= rstate_out; cnt_reg <= cnt_reg + 32'd1;
                    iter_reg <= iter_reg + 4'd1;
                    launch_reg <= 1'b1;   // last one starts the data block
                end
                ST_DATA: if (rdone) begin
                    mix_reg <= rstate_out; cnt_reg <= cnt_reg + 32'd1;
                    ov_reg <= 1'b1; okind_reg <= 1'b0; ook_reg <= 1'b0;
                    oword_reg <= dir_reg ? plain : ((plain ^ mix_reg[0]) & dmask);
                    olast_reg <= !last_reg;
                    iter_reg <= '0;
                end
                ST_FIN: begin
                    if (iter_reg == 4'd0 && !ov_reg && !launch_reg && !rdone
                        && !u_busy) begin
                        mix_reg[0] <= mix_reg[0] ^ FinishConst;
                        launch_reg <= 1'b1;
                    end
                    if (rdone) begin
                        mix_reg <= rstate_out; cnt_reg <= cnt_reg + 32'd1;
                        iter_reg <= (iter_reg == 4'd7) ? 4'd0 : iter_reg + 4'd1;
                        if (iter_reg == 4'd7) tag_reg[0] <= rstate_out[0];
                        launch_reg <= 1'b1;
                    end
                end
                ST_TAG: if (rdone) begin
                    mix_reg <= rstate_out; cnt_reg <= cnt_reg + 32'd1;
                    tag_reg[iter_reg[1:0] + 2'd1] <= rstate_out[0];
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg != 4'd2) launch_reg <= 1'b1;
                    else begin
                        iter_reg <= '0;
                        ov_reg <= 1'b1; okind_reg <= 1'b1; ook_reg <= 1'b0;
                        oword_reg <= tag_reg[0]; olast_reg <= 1'b0;
                    end
                end
                ST_OUT: if (take_out && iter_reg != 4'd3) begin
                    iter_reg <= iter_reg + 4'd1;
                    ov_reg <= 1'b1;
                    oword_reg <= tag_reg[iter_reg[1:0] + 2'd1];
                    olast_reg <= (iter_reg == 4'd2);
                end else if (take_out) begin
                    mix_reg <= '0; cnt_reg <= '0; inmsg_reg <= 1'b0;
                    for (int i = 0; i < 8; i++) rk_reg[i] <= '0;
                    tidx_reg <= '0; mism_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // round unit busy tracker (mirrors launch/done)
    always_ff @(posedge aclk) begin
        if (!aresetn) u_busy <= 1'b0;
        else if (launch_reg) u_busy <= 1'b1;
        else if (rdone) u_busy <= 1'b0;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, ook_reg, oword_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    // no new item while results wait
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg |-> !s_tready) else $error("accept while result pending");
    // a verdict carries a zero word
    a_verdict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
        else $error("verdict with nonzero word");
    // round unit is never restarted mid-block
    a_round_start: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |-> !u_busy || rdone) else $error("round unit overrun");
endmodule

/* rtl/hscm_round.sv */
// Helix block round unit: five add/xor/rotate steps per cycle, with the round
// phases of each block counted by ph_reg. Depends on hscm_pkg.
module hscm_round (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hscm_pkg::round_ctl_t   ctl,
    input  hscm_pkg::mix_t         state_in,
    output hscm_pkg::mix_t         state_out,
    output logic                   done
);
    import hscm_pkg::*;

    mix_t       st_reg;
    logic [1:0] ph_reg;
    logic       busy_reg;
    round_ctl_t c_reg;
    mix_t       st_next;
    word_t      a, b, c, d, e;

    always_comb begin
        a = st_reg[0]; b = st_reg[1]; c = st_reg[2];
        d = st_reg[3]; e = st_reg[4];
        unique case (ph_reg)
            2'd0, 2'd2: begin
                a = (ph_reg == 2'd2) ? a + (d ^ c_reg.p) : a + d;
                d = rol(d, 15);
                b = b + e; e = rol(e, 25);
                c = c ^ a; a = rol(a, 9);
                d = d ^ b; b = rol(b, 10);
                e = e + c; c = rol(c, 17);
            end
            default: begin
                a = a ^ (d + ((ph_reg == 2'd3) ? c_reg.x1 : c_reg.x0));
                d = rol(d, 30);
                b = b ^ e; e = rol(e, 13);
                c = c + a; a = rol(a, 20);
                d = d + b; b = rol(b, 11);
                e = e ^ c; c = rol(c, 5);
            end
        endcase
        st_next = {e, d, c, b, a};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= '0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
            ph_reg   <= '0;
            st_reg   <= state_in;
            c_reg    <= ctl;
        end else if (busy_reg) begin
            st_reg <= st_next;
            ph_reg <= ph_reg + 2'd1;
            if (ph_reg == 2'd3) busy_reg <= 1'b0;
        end
    end

    assign state_out = st_next;
    assign done      = busy_reg && (ph_reg == 2'd3);
endmodule

/* tb/sv/tb_top.sv */
// Testbench for helix_stream_cipher_with_mac: directed table, register extremes with tag
// checks, then random messages, checked against an internal Helix predictor. Depends on hscm_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hscm_pkg::*;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_TAG  = 1'b1;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TAG  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic        ok;
        logic        last;
    } res_t;

    typedef struct {
        logic        req;
        logic [31:0] word;
        logic [2:0]  vb;
        logic        last;
        logic        has_gold;   // typed-in expectation for the first result
        res_t        gold;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // word_in[31:0], valid_bytes[34:32]
    logic        s_tuser = 1'b0; // req_type
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // word_out[31:0], tag_ok[32]
    logic        m_tuser;        // kind
    logic        m_tlast;

    helix_stream_cipher_with_mac u_top (.*);

    always #6 aclk = ~aclk;

    // predictor copy of registers and cipher state
    logic [63:0] key_reg [4];
    logic [5:0]  klen_reg;
    logic [63:0] nlo_reg, nhi_reg;
    logic        dir_reg;
    word_t       mx [5];
    word_t       wk [8];
    word_t       rk1 [8];
    word_t       blk_cnt;
    logic        msg_open;
    word_t       tag_words [4];
    logic [1:0]  tag_idx;
    logic        tag_bad;

    res_t        pending_results [$];
    int          n_errors = 0;
    logic        stall_pat;

    task automatic report_mismatch(input string what, input res_t got, input res_t want);
        $display("MISMATCH %s: got k=%0d w=%h ok=%0d l=%0d want k=%0d w=%h ok=%0d l=%0d",
                 what, got.kind, got.word, got.ok, got.last,
                 want.kind, want.word, want.ok, want.last);
        n_errors++;
    endtask

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t bytes_mask(int n);
        if (n <= 0) return 32'h0;
        if (n >= 4) return 32'hFFFF_FFFF;
        return (32'h1 << (8 * n)) - 1;
    endfunction

    task automatic helix_rounds(word_t x0, word_t p, word_t x1);
        word_t a, b, c, d, e;
        a = mx[0]; b = mx[1]; c = mx[2]; d = mx[3]; e = mx[4];
        for (int h = 0; h < 2; h++) begin
            a += h ? (d ^ p) : d;
            d = rotl(d, 15);
            b += e; e = rotl(e, 25);
            c ^= a; a = rotl(a, 9);
            d ^= b; b = rotl(b, 10);
            e += c; c = rotl(c, 17);
            a ^= (d + (h ? x1 : x0)); d = rotl(d, 30);
            b ^= e; e = rotl(e, 13);
            c += a; a = rotl(a, 20);
            d += b; b = rotl(b, 11);
            e ^= c; c = rotl(c, 5);
        end
        mx[0] = a; mx[1] = b; mx[2] = c; mx[3] = d; mx[4] = e;
    endtask

    task automatic keyed_round(word_t p);
        int i;
        i = blk_cnt[2:0];
        helix_rounds(wk[i], p, rk1[i] + blk_cnt);
        blk_cnt++;
    endtask

    // key schedule and nonce setup at message start
    task automatic open_message();
        int kl;
        word_t nw [8];
        word_t k [4];
        kl = (klen_reg > 32) ? 32 : klen_reg;
        for (int i = 0; i < 8; i++) begin
            wk[i] = '0;
            for (int j = 0; j < 4; j++)
                if (4 * i + j < kl)
                    wk[i][8*j +: 8] = key_reg[(4*i+j) >> 3][8*((4*i+j) & 7) +: 8];
        end
        for (int r = 0; r < 8; r++) begin
            for (int i = 0; i < 4; i++) begin
                k[i] = wk[i];
                mx[i] = wk[i];
            end
            mx[4] = kl + KeyLenBias;
            helix_rounds('0, '0, '0);
            for (int i = 0; i < 4; i++) begin
                wk[i] = wk[i+4] ^ mx[i];
                wk[i+4] = k[i];
            end
        end
        nw[0] = nlo_reg[31:0]; nw[1] = nlo_reg[63:32];
        nw[2] = nhi_reg[31:0]; nw[3] = nhi_reg[63:32];
        for (int i = 0; i < 4; i++) nw[i+4] = i - nw[i];
        for (int i = 0; i < 8; i++)
            rk1[i] = wk[(i + 4) & 7] + nw[i] + (((i & 3) == 1) ? 4 * kl : 0);
        for (int i = 0; i < 4; i++) mx[i] = wk[i+3] ^ nw[i];
        mx[4] = wk[7];
        blk_cnt = '0;
        for (int i = 0; i < 8; i++) keyed_round('0);
    endtask

    task automatic predict_item(logic req, word_t w, logic [2:0] vb_in, logic last);
        int vb, base;
        word_t m, z0, pt, lm4;
        res_t r;
        if (req == REQ_TAG) begin
            if (!dir_reg || msg_open) return;
            base = 4 * tag_idx;
            m = bytes_mask(base < TagBytes ? TagBytes - base : 0);
            if (((w ^ tag_words[tag_idx]) & m) != 0) tag_bad = 1'b1;
            tag_idx++;
            if (!last) return;
            pending_results.push_back('{KIND_TAG, 32'h0, !tag_bad, 1'b1});
            tag_idx = '0; tag_bad = 1'b0;
            return;
        end
        if (!msg_open) begin
            open_message();
            msg_open = 1'b1;
        end
        vb = (!last || vb_in == 0 || vb_in > 4) ? 4 : vb_in;
        m = bytes_mask(vb);
        z0 = mx[0];
        if (!dir_reg) begin
            pt = w & m;
            r = '{KIND_DATA, (pt ^ z0) & m, 1'b0, !last};
        end else begin
            pt = (w ^ z0) & m;
            r = '{KIND_DATA, pt, 1'b0, !last};
        end
        keyed_round(pt);
        pending_results.push_back(r);
        if (!last) return;
        lm4 = vb & 3;
        mx[0] ^= FinishConst;
        for (int i = 0; i < 8; i++) keyed_round(lm4);
        for (int i = 0; i < 4; i++) begin
            tag_words[i] = mx[0];
            if (i < 3) keyed_round(lm4);
        end
        for (int i = 0; i < 4; i++)
            pending_results.push_back('{KIND_TAG, tag_words[i], 1'b0, i == 3});
        for (int i = 0; i < 5; i++) mx[i] = '0;
        for (int i = 0; i < 8; i++) rk1[i] = '0;
        blk_cnt = '0; msg_open = 1'b0; tag_idx = '0; tag_bad = 1'b0;
    endtask

    // APB write: setup then access cycle, then psel drops to idle; mirrored into the predictor
    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        if (idx < RegKlen) key_reg[idx[1:0]] = v;
        else if (idx == RegKlen) klen_reg = v[5:0];
        else if (idx == RegNlow) nlo_reg = v;
        else if (idx == RegNhigh) nhi_reg = v;
        else dir_reg = v[0];
    endtask

    // drop valid, wait for all results to drain, then let a late tag pass settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    int burst_left = 0;

    // send one item; sender bursts with random gaps between them. Valid stays
    // high after the handshake until the next item, a gap or a drain.
    task automatic send_item(logic req, word_t w, logic [2:0] vb, logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, vb, w};
        s_tuser <= req;
        s_tlast <= last;
        predict_item(req, w, vb, last);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // random message: 1..6 data words, sometimes 9..20, random tail bytes, sometimes tag check
    task automatic random_message(inout int sent);
        int nw;
        nw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        for (int i = 0; i < nw; i++) begin
            send_item(REQ_DATA, $urandom, 3'($urandom_range(0, 7)), i == nw - 1);
            sent++;
        end
        if (dir_reg && $urandom_range(0, 2) != 0) begin
            nw = $urandom_range(1, 5);
            for (int i = 0; i < nw; i++) begin
                // mostly the true tag, sometimes with a flipped bit
                send_item(REQ_TAG,
                          tag_words[tag_idx] ^ (($urandom_range(0, 3) == 0) ?
                              (32'h1 << $urandom_range(0, 31)) : 32'h0),
                          3'($urandom_range(0, 7)), i == nw - 1);
                sent++;
            end
        end
        if ($urandom_range(0, 15) == 0) begin
            // noise: a random tag word after the message; ignored in encrypt mode, checked in decrypt mode
            send_item(REQ_TAG, $urandom, 3'd4, 1'($urandom_range(0, 1)));
        end
    endtask

    // receiver stall pattern: alternating runs of ready/stall
    initial begin
        int run;
        stall_pat = 1'b1;
        forever begin
            run = $urandom_range(1, 20);
            repeat (run) begin
                @(posedge aclk);
                m_tready <= stall_pat ? 1'b1 : ($urandom_range(0, 3) == 0);
            end
            stall_pat = $urandom_range(0, 2) != 0;
        end
    end

    // result checker
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[31:0], m_tdata[32], m_tlast};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected", got, got);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) report_mismatch("kind", got, want);
                if (got.word !== want.word) report_mismatch("word", got, want);
                if (got.ok !== want.ok) report_mismatch("tag_ok", got, want);
                if (got.last !== want.last) report_mismatch("last", got, want);
            end
        end
    end

    row_t directed [$];

    initial begin
        int sent;
        int n_before;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        klen_reg = '0; nlo_reg = '0; nhi_reg = '0; dir_reg = 1'b0;
        for (int i = 0; i < 5; i++) mx[i] = '0;
        for (int i = 0; i < 8; i++) begin wk[i] = '0; rk1[i] = '0; end
        for (int i = 0; i < 4; i++) tag_words[i] = '0;
        blk_cnt = '0; msg_open = 1'b0; tag_idx = '0; tag_bad = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: widths extremes, short tails, ignored tag words
        directed = '{
            '{REQ_TAG,  32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, '0},  // encrypt mode: ignored
            '{REQ_DATA, 32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
            '{REQ_DATA, 32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, '0},  // tail ignored mid-message
            '{REQ_DATA, 32'hA5A5_5A5A, 3'd1, 1'b1, 1'b0, '0},
            '{REQ_DATA, 32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0, '0},
            '{REQ_DATA, 32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0, '0},
            '{REQ_DATA, 32'h1234_5678, 3'd0, 1'b1, 1'b0, '0},  // zero bytes counts as four
            '{REQ_DATA, 32'h8765_4321, 3'd7, 1'b1, 1'b0, '0},  // above four counts as four
            '{REQ_DATA, 32'h0000_0001, 3'd5, 1'b0, 1'b0, '0},
            '{REQ_DATA, 32'h8000_0000, 3'd6, 1'b1, 1'b0, '0}
        };
        foreach (directed[i]) begin
            n_before = pending_results.size();
            send_item(directed[i].req, directed[i].word, directed[i].vb, directed[i].last);
            // typed-in rows: the first predicted result must match the table
            if (directed[i].has_gold) begin
                if (pending_results.size() <= n_before)
                    report_mismatch("table", '0, directed[i].gold);
                else if (pending_results[n_before] !== directed[i].gold)
                    report_mismatch("table", pending_results[n_before], directed[i].gold);
            end
        end
        drain();

        // key, nonce and direction extremes; decrypt with tag checks
        reg_write(RegKey0, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(RegKey1, 64'h0123_4567_89AB_CDEF);
        reg_write(RegKey2, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(RegKey3, 64'h8000_0000_0000_0001);
        reg_write(RegKlen, 64'd63);          // above 32 acts as 32
        reg_write(RegNlow, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(RegNhigh, 64'h0);
        reg_write(RegDir, 64'd1);
        send_item(REQ_DATA, 32'hDEAD_BEEF, 3'd4, 1'b0);
        send_item(REQ_TAG, 32'h0, 3'd4, 1'b1);       // during a message: ignored
        send_item(REQ_DATA, 32'hFFFF_FFFF, 3'd3, 1'b1);
        // exact tag, then a corrupted tag, then five words (index wrap)
        for (int i = 0; i < 4; i++) send_item(REQ_TAG, tag_words[i], 3'd4, i == 3);
        for (int i = 0; i < 4; i++)
            send_item(REQ_TAG, tag_words[i] ^ (i == 2 ? 32'h0100_0000 : 32'h0), 3'd4, i == 3);
        for (int i = 0; i < 5; i++) send_item(REQ_TAG, tag_words[i & 3], 3'd4, i == 4);
        send_item(REQ_TAG, tag_words[0], 3'd4, 1'b1);  // short tag: one word compared
        drain();

        // random phases with fresh register settings between them
        sent = 0;
        for (int ph = 0; sent < 270; ph++) begin
            for (int r = 0; r < 4; r++) reg_write(r[2:0], {$urandom, $urandom});
            reg_write(RegKlen, (ph % 4 == 0) ? 64'd0 : 64'($urandom_range(0, 63)));
            reg_write(RegNlow, {$urandom, $urandom});
            reg_write(RegNhigh, (ph % 5 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
            reg_write(RegDir, 64'(ph % 2));
            for (int m = 0; m < 6; m++) random_message(sent);
            drain();   // sender holds off until all results are in
        end

        drain();
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
rtl/hscm_pkg.sv
rtl/hscm_round.sv
rtl/helix_stream_cipher_with_mac.sv
tb/sv/tb_top.sv
